### design/lagrange_interp_1d_lin_quad_assert.svh
// Assertion macros used by the checker module of the interpolator.
// Depends on nothing; include by bare file name inside a module body.
`ifndef LAGRANGE_INTERP_1D_LIN_QUAD_ASSERT_SVH
`define LAGRANGE_INTERP_1D_LIN_QUAD_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define LAGINT_ASSERT_NOW(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("interpolator check failed");

// Next-cycle implication, disabled while reset is high.
`define LAGINT_ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("interpolator check failed");

// Next-cycle implication that is also checked during reset.
`define LAGINT_ASSERT_ALWAYS_NEXT(label, clk, a, c) \
  label: assert property (@(posedge clk) (a) |=> (c)) \
    else $error("interpolator check failed");

`endif

### design/lagint_pkg.sv
// Shared constants of the 1-D Lagrange interpolator: default widths,
// configuration register indexes and field counts. No dependencies.
`timescale 1ns / 1ps

package lagint_pkg;

  localparam int VALUE_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF   = 16;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_NODE_POS_A = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NODE_POS_B = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NODE_POS_C = 2'd2;

  localparam int NUM_IN_VALUES  = 7;
  localparam int NUM_OUT_VALUES = 4;
  localparam int NUM_RATIOS     = 6;

endpackage

### design/lagrange_interp_1d_lin_quad.sv
// Top level of the 1-D linear and quadratic Lagrange interpolator.
// Depends on lagint_pkg for default widths and register indexes.
`timescale 1ns / 1ps

// Usage.
// The slave stream carries one item per query: s_tdata holds, from the lowest
// bit up, query_pos, primal_node_a/b/c and adjoint_node_a/b/c, each
// VALUE_WIDTH bits, and s_tlast carries the last_element marker. The master
// stream returns one item per input: m_tdata holds primal_linear,
// adjoint_linear, primal_quadratic and adjoint_quadratic from the lowest bit
// up, m_tuser is the nodes_degenerate flag and m_tlast copies the marker.
// The three node coordinates must be written through cfg_we/cfg_index/
// cfg_data only while no item is in flight; the block does not enforce it.
// Throughput is one item per clock while the skid register is empty. Values
// are Q16.16 at the default widths. The pipeline is the input register, the
// six ratio dividers, which resolve one quotient bit per stage over
// VALUE_WIDTH + FRAC_BITS + 1 stages, then the weight, weight product, weight
// round/saturate, value product, sum and round/saturate stages.
// A stalled receiver is absorbed by an output register plus a one-item skid
// register; the pipeline freezes only once the skid register is full, and
// s_tready drops in that case. Reset empties the pipeline and loads the
// nodes with 0.0, 1.0 and 2.0.
module lagrange_interp_1d_lin_quad
  import lagint_pkg::*;
#(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
  input  logic                                          clk,
  input  logic                                          rst,
  input  logic                                          s_tvalid,
  output logic                                          s_tready,
  // query_pos, primal_node_a, primal_node_b, primal_node_c,
  // adjoint_node_a, adjoint_node_b, adjoint_node_c, zero padding
  input  logic [((NUM_IN_VALUES*VALUE_WIDTH+7)/8)*8-1:0]  s_tdata,
  input  logic                                          s_tlast,
  output logic                                          m_tvalid,
  input  logic                                          m_tready,
  // primal_linear, adjoint_linear, primal_quadratic, adjoint_quadratic,
  // zero padding
  output logic [((NUM_OUT_VALUES*VALUE_WIDTH+7)/8)*8-1:0] m_tdata,
  // nodes_degenerate
  output logic                                          m_tuser,
  output logic                                          m_tlast,
  input  logic                                          cfg_we,
  input  logic [CFG_IDX_W-1:0]                          cfg_index,
  input  logic [VALUE_WIDTH-1:0]                        cfg_data
);

  localparam int VW     = VALUE_WIDTH;
  localparam int FB     = FRAC_BITS;
  localparam int NW     = VW + FB + 1;     // quotient bits and divider stages
  localparam int PW     = 2 * VW;          // product width
  localparam int SW     = PW + 2;          // dot-product sum width
  localparam int OUT_DW = ((NUM_OUT_VALUES * VW + 7) / 8) * 8;
  localparam int RW     = NUM_OUT_VALUES * VW + 2;

  localparam logic [VW-1:0] RST_B = VW'(1) << FB;
  localparam logic [VW-1:0] RST_C = VW'(2) << FB;

  localparam logic signed [VW-1:0] VMAX = {1'b0, {(VW-1){1'b1}}};
  localparam logic signed [VW-1:0] VMIN = {1'b1, {(VW-1){1'b0}}};
  localparam logic [NW-1:0] MAG_POS_MAX = {{(NW-VW+1){1'b0}}, {(VW-1){1'b1}}};
  localparam logic [NW-1:0] MAG_NEG_MAX = {{(NW-VW){1'b0}}, 1'b1, {(VW-1){1'b0}}};
  localparam logic signed [PW-1:0] P_HALF = PW'(1) << (FB - 1);
  localparam logic signed [PW-1:0] P_MAX  = {{(PW-VW+1){1'b0}}, {(VW-1){1'b1}}};
  localparam logic signed [PW-1:0] P_MIN  = {{(PW-VW+1){1'b1}}, {(VW-1){1'b0}}};
  localparam logic signed [SW-1:0] S_HALF = SW'(1) << (FB - 1);
  localparam logic signed [SW-1:0] S_MAX  = {{(SW-VW+1){1'b0}}, {(VW-1){1'b1}}};
  localparam logic signed [SW-1:0] S_MIN  = {{(SW-VW+1){1'b1}}, {(VW-1){1'b0}}};

  // ---------------------------------------------------------------------
  // Configuration: node coordinates, to change only while idle (not enforced
  // here); the derived denominators are used directly by every divider stage.
  // ---------------------------------------------------------------------
  logic [VW-1:0] node_a, node_b, node_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      node_a <= '0;
      node_b <= RST_B;
      node_c <= RST_C;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_NODE_POS_A: node_a <= cfg_data;
        REG_NODE_POS_B: node_b <= cfg_data;
        REG_NODE_POS_C: node_c <= cfg_data;
        default: ;
      endcase
    end
  end

  logic signed [VW:0] xa_e, xb_e, xc_e;
  logic signed [VW:0] den [NUM_RATIOS];
  logic [VW-1:0]      ud  [NUM_RATIOS];
  logic [NUM_RATIOS-1:0] den_neg;
  logic                  degen;

  assign xa_e = {node_a[VW-1], node_a};
  assign xb_e = {node_b[VW-1], node_b};
  assign xc_e = {node_c[VW-1], node_c};
  assign degen = (node_a == node_b) || (node_a == node_c) || (node_b == node_c);

  // Ratio order: (q-b)/(a-b), (q-a)/(b-a), (q-c)/(a-c), (q-c)/(b-c),
  // (q-a)/(c-a), (q-b)/(c-b). The first two are also the linear weights.
  always_comb begin
    den[0] = xa_e - xb_e;
    den[1] = xb_e - xa_e;
    den[2] = xa_e - xc_e;
    den[3] = xb_e - xc_e;
    den[4] = xc_e - xa_e;
    den[5] = xc_e - xb_e;
    for (int k = 0; k < NUM_RATIOS; k++) begin
      den_neg[k] = den[k][VW];
      ud[k]      = den_neg[k] ? VW'(-den[k]) : den[k][VW-1:0];
    end
  end

  // ---------------------------------------------------------------------
  // Flow control: the pipeline moves as one while the skid slot is empty.
  // ---------------------------------------------------------------------
  logic en;
  logic skid_valid;

  assign en       = !skid_valid;
  assign s_tready = en;

  // ---------------------------------------------------------------------
  // Input register.
  // ---------------------------------------------------------------------
  logic          s0_valid;
  logic [VW-1:0] s0_q;
  logic [VW-1:0] s0_pv [3];
  logic [VW-1:0] s0_av [3];
  logic          s0_last;

  always_ff @(posedge clk) begin
    if (en) begin
      s0_q    <= s_tdata[VW-1:0];
      s0_last <= s_tlast;
      for (int i = 0; i < 3; i++) begin
        s0_pv[i] <= s_tdata[(i+1)*VW +: VW];
        s0_av[i] <= s_tdata[(i+4)*VW +: VW];
      end
    end
  end

  // Numerator magnitudes and quotient signs.
  logic signed [VW:0] qe, nq_a, nq_b, nq_c;
  logic signed [VW:0] num [NUM_RATIOS];
  logic [VW-1:0]      un  [NUM_RATIOS];
  logic [NUM_RATIOS-1:0] q_neg;

  always_comb begin
    qe   = {s0_q[VW-1], s0_q};
    nq_a = qe - xa_e;
    nq_b = qe - xb_e;
    nq_c = qe - xc_e;
    num[0] = nq_b;
    num[1] = nq_a;
    num[2] = nq_c;
    num[3] = nq_c;
    num[4] = nq_a;
    num[5] = nq_b;
    for (int k = 0; k < NUM_RATIOS; k++) begin
      un[k]    = num[k][VW] ? VW'(-num[k]) : num[k][VW-1:0];
      q_neg[k] = num[k][VW] ^ den_neg[k];
    end
  end

  // ---------------------------------------------------------------------
  // Divider pipeline: restoring division of un * 2^(FB+1) by ud, one
  // quotient bit per stage. The low bits of dnum fill with quotient bits
  // as the numerator shifts out at the top.
  // ---------------------------------------------------------------------
  localparam int PAYW = 6 * VW + 1;

  logic [NW:0]             dvalid;
  logic [VW-1:0]           drem [NW+1][NUM_RATIOS];
  logic [NW-1:0]           dnum [NW+1][NUM_RATIOS];
  logic [NUM_RATIOS-1:0]   dneg [NW+1];
  logic [PAYW-1:0]         dpay [NW+1];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < NUM_RATIOS; k++) begin
        drem[0][k] <= '0;
        dnum[0][k] <= {un[k], {(FB+1){1'b0}}};
      end
      dneg[0] <= q_neg;
      dpay[0] <= {s0_last, s0_av[2], s0_av[1], s0_av[0],
                  s0_pv[2], s0_pv[1], s0_pv[0]};
    end
  end

  for (genvar j = 1; j <= NW; j++) begin : g_div
    logic [VW:0]   trial [NUM_RATIOS];
    logic [VW:0]   diff  [NUM_RATIOS];
    logic [NUM_RATIOS-1:0] ge;

    always_comb begin
      for (int k = 0; k < NUM_RATIOS; k++) begin
        trial[k] = {drem[j-1][k], dnum[j-1][k][NW-1]};
        diff[k]  = trial[k] - {1'b0, ud[k]};
        ge[k]    = trial[k] >= {1'b0, ud[k]};
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        for (int k = 0; k < NUM_RATIOS; k++) begin
          drem[j][k] <= ge[k] ? diff[k][VW-1:0] : trial[k][VW-1:0];
          dnum[j][k] <= {dnum[j-1][k][NW-2:0], ge[k]};
        end
        dneg[j] <= dneg[j-1];
        dpay[j] <= dpay[j-1];
      end
    end
  end

  // ---------------------------------------------------------------------
  // Weight stage: round half away from zero, apply sign, saturate.
  // ---------------------------------------------------------------------
  logic [NW:0]   inc [NUM_RATIOS];
  logic [NW-1:0] mag [NUM_RATIOS];
  logic signed [VW-1:0] wt [NUM_RATIOS];

  always_comb begin
    for (int k = 0; k < NUM_RATIOS; k++) begin
      inc[k] = {1'b0, dnum[NW][k]} + (NW+1)'(1);
      mag[k] = inc[k][NW:1];
      if (dneg[NW][k]) begin
        wt[k] = (mag[k] > MAG_NEG_MAX) ? VMIN : VW'(-mag[k]);
      end else begin
        wt[k] = (mag[k] > MAG_POS_MAX) ? VMAX : mag[k][VW-1:0];
      end
    end
  end

  logic                 w_valid;
  logic signed [VW-1:0] w_r [NUM_RATIOS];
  logic [PAYW-1:0]      w_pay;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < NUM_RATIOS; k++) w_r[k] <= wt[k];
      w_pay <= dpay[NW];
    end
  end

  // Quadratic weight products.
  logic                 m1_valid;
  logic signed [PW-1:0] m1_p [3];
  logic signed [VW-1:0] m1_wl [2];
  logic [PAYW-1:0]      m1_pay;

  always_ff @(posedge clk) begin
    if (en) begin
      m1_p[0]  <= w_r[0] * w_r[2];
      m1_p[1]  <= w_r[1] * w_r[3];
      m1_p[2]  <= w_r[4] * w_r[5];
      m1_wl[0] <= w_r[0];
      m1_wl[1] <= w_r[1];
      m1_pay   <= w_pay;
    end
  end

  // Round half up and saturate the quadratic weights.
  logic signed [PW-1:0] m2_rnd [3];
  logic signed [PW-1:0] m2_sh  [3];
  logic signed [VW-1:0] m2_w   [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      m2_rnd[i] = m1_p[i] + P_HALF;
      m2_sh[i]  = m2_rnd[i] >>> FB;
      if (m2_sh[i] > P_MAX)      m2_w[i] = VMIN ^ VMIN ^ VMAX;
      else if (m2_sh[i] < P_MIN) m2_w[i] = VMIN;
      else                       m2_w[i] = m2_sh[i][VW-1:0];
    end
  end

  logic                 m2_valid;
  logic signed [VW-1:0] m2_wq [3];
  logic signed [VW-1:0] m2_wl [2];
  logic [PAYW-1:0]      m2_pay;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) m2_wq[i] <= m2_w[i];
      m2_wl  <= m1_wl;
      m2_pay <= m1_pay;
    end
  end

  // Value times weight products.
  logic signed [VW-1:0] pv [3];
  logic signed [VW-1:0] av [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pv[i] = m2_pay[i*VW +: VW];
      av[i] = m2_pay[(i+3)*VW +: VW];
    end
  end

  logic                 p1_valid;
  logic signed [PW-1:0] p1_pl [2];
  logic signed [PW-1:0] p1_al [2];
  logic signed [PW-1:0] p1_pq [3];
  logic signed [PW-1:0] p1_aq [3];
  logic                 p1_last;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 2; i++) begin
        p1_pl[i] <= pv[i] * m2_wl[i];
        p1_al[i] <= av[i] * m2_wl[i];
      end
      for (int i = 0; i < 3; i++) begin
        p1_pq[i] <= pv[i] * m2_wq[i];
        p1_aq[i] <= av[i] * m2_wq[i];
      end
      p1_last <= m2_pay[PAYW-1];
    end
  end

  // Exact sums plus the rounding half.
  logic                 p2_valid;
  logic signed [SW-1:0] p2_sum [NUM_OUT_VALUES];
  logic                 p2_last;

  always_ff @(posedge clk) begin
    if (en) begin
      p2_sum[0] <= SW'(p1_pl[0]) + SW'(p1_pl[1]) + S_HALF;
      p2_sum[1] <= SW'(p1_al[0]) + SW'(p1_al[1]) + S_HALF;
      p2_sum[2] <= SW'(p1_pq[0]) + SW'(p1_pq[1]) + SW'(p1_pq[2]) + S_HALF;
      p2_sum[3] <= SW'(p1_aq[0]) + SW'(p1_aq[1]) + SW'(p1_aq[2]) + S_HALF;
      p2_last   <= p1_last;
    end
  end

  // Floor shift, saturate; a degenerate node set forces zeros.
  logic signed [SW-1:0] p3_sh [NUM_OUT_VALUES];
  logic signed [VW-1:0] p3_v  [NUM_OUT_VALUES];

  always_comb begin
    for (int i = 0; i < NUM_OUT_VALUES; i++) begin
      p3_sh[i] = p2_sum[i] >>> FB;
      if (degen)                 p3_v[i] = '0;
      else if (p3_sh[i] > S_MAX) p3_v[i] = VMAX;
      else if (p3_sh[i] < S_MIN) p3_v[i] = VMIN;
      else                       p3_v[i] = p3_sh[i][VW-1:0];
    end
  end

  logic          fin_valid;
  logic [RW-1:0] fin;

  always_ff @(posedge clk) begin
    if (en) begin
      fin <= {p2_last, degen, p3_v[3], p3_v[2], p3_v[1], p3_v[0]};
    end
  end

  // Valid bits of every stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid  <= 1'b0;
      dvalid    <= '0;
      w_valid   <= 1'b0;
      m1_valid  <= 1'b0;
      m2_valid  <= 1'b0;
      p1_valid  <= 1'b0;
      p2_valid  <= 1'b0;
      fin_valid <= 1'b0;
    end else if (en) begin
      s0_valid  <= s_tvalid;
      dvalid    <= {dvalid[NW-1:0], s0_valid};
      w_valid   <= dvalid[NW];
      m1_valid  <= w_valid;
      m2_valid  <= m1_valid;
      p1_valid  <= m2_valid;
      p2_valid  <= p1_valid;
      fin_valid <= p2_valid;
    end
  end

  // ---------------------------------------------------------------------
  // Output register with a one-item skid slot.
  // ---------------------------------------------------------------------
  logic          out_valid;
  logic [RW-1:0] out_data;
  logic [RW-1:0] skid_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_valid && !m_tready) begin
      if (en && fin_valid) begin
        skid_valid <= 1'b1;
      end
    end else if (skid_valid) begin
      out_valid  <= 1'b1;
      skid_valid <= 1'b0;
    end else begin
      out_valid <= fin_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_valid && !m_tready) begin
      if (en && fin_valid) skid_data <= fin;
    end else if (skid_valid) begin
      out_data <= skid_data;
    end else begin
      out_data <= fin;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = OUT_DW'(out_data[NUM_OUT_VALUES*VW-1:0]);
  assign m_tuser  = out_data[RW-2];
  assign m_tlast  = out_data[RW-1];

endmodule

### design/lagint_chk.sv
// Port-level checker for the interpolator, attached by a bind statement.
// Depends on lagint_pkg and the assertion macro header.
`timescale 1ns / 1ps

module lagint_chk
  import lagint_pkg::*;
#(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input logic                                          clk,
  input logic                                          rst,
  input logic                                          s_tready,
  input logic                                          m_tvalid,
  input logic                                          m_tready,
  input logic [((NUM_OUT_VALUES*VALUE_WIDTH+7)/8)*8-1:0] m_tdata,
  input logic                                          m_tuser
);

  `include "lagrange_interp_1d_lin_quad_assert.svh"

  // A held result keeps its payload.
  `LAGINT_ASSERT_NEXT(a_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

  // Coinciding nodes give zero values.
  `LAGINT_ASSERT_NOW(a_degen_zero, clk, rst, m_tvalid && m_tuser, m_tdata == '0)

  // Reset leaves no result on the output.
  `LAGINT_ASSERT_ALWAYS_NEXT(a_rst_empty, clk, rst, !m_tvalid)

  // A full skid slot cannot drain while the output is stalled.
  `LAGINT_ASSERT_NEXT(a_skid_holds, clk, rst, !s_tready && m_tvalid && !m_tready, !s_tready)

endmodule

bind lagrange_interp_1d_lin_quad lagint_chk #(
  .VALUE_WIDTH(VALUE_WIDTH)
) u_lagint_chk (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

### verif/tb_lagrange_interp_1d_lin_quad.sv
// Self-checking testbench for the 1-D linear/quadratic Lagrange interpolator.
// Depends on lagint_pkg and lagrange_interp_1d_lin_quad; holds its own predictor.
`timescale 1ns / 1ps

module tb_lagrange_interp_1d_lin_quad;
  import lagint_pkg::*;

  localparam int VW = VALUE_WIDTH_DEF;
  localparam int FB = FRAC_BITS_DEF;
  // Latency of the pipeline plus margin, used for the pause before a
  // configuration write and at the end of the run.
  localparam int DRAIN_CYCLES = VW + FB + 9 + 20;
  localparam int CYCLE_LIMIT = 400000;

  localparam longint VMAX = 64'sd2147483647;
  localparam longint VMIN = -64'sd2147483648;
  localparam longint ONE = 64'sd1 << FB;

  typedef logic signed [VW-1:0] fix_t;

  // One query: position, primal and adjoint node values, marker.
  typedef struct {
    fix_t query;
    fix_t primal[3];
    fix_t adjoint[3];
    logic last;
  } query_t;

  // One interpolation result as the block should return it.
  typedef struct {
    fix_t primal_lin;
    fix_t adjoint_lin;
    fix_t primal_quad;
    fix_t adjoint_quad;
    logic degenerate;
    logic last;
  } interp_t;

  // Interpolation predictor with its own copy of the node coordinates.
  class interp_scoreboard;
    fix_t nodes[3];
    interp_t pending[$];
    int mismatches;
    int results_seen;
    int degenerate_seen;

    function void reset_nodes();
      nodes[0] = fix_t'(0);
      nodes[1] = fix_t'(ONE);
      nodes[2] = fix_t'(2 * ONE);
    endfunction

    function longint clamp(logic signed [127:0] v);
      if (v > VMAX) return VMAX;
      if (v < VMIN) return VMIN;
      return longint'(v);
    endfunction

    // n/d with FB fraction bits, rounded half away from zero, saturated.
    function longint weight_ratio(longint n, longint d);
      longint unsigned un, ud, q, mag;
      logic neg;
      if (n == 0 || d == 0) return 0;
      neg = (n < 0) != (d < 0);
      un = (n < 0) ? -n : n;
      ud = (d < 0) ? -d : d;
      q = (un << (FB + 1)) / ud;
      mag = (q + 1) >> 1;
      if (neg) return (mag > longint'(VMAX) + 1) ? VMIN : -longint'(mag);
      return (mag > VMAX) ? VMAX : longint'(mag);
    endfunction

    // Product of two weights, rounded half up, saturated.
    function longint weight_mul(longint a, longint b);
      logic signed [127:0] p;
      p = a * b;
      return clamp((p + (1 << (FB - 1))) >>> FB);
    endfunction

    // Exact sum of value times weight, rounded once half up, saturated.
    function longint weighted_sum(fix_t v[3], longint w[3], int n);
      logic signed [127:0] acc;
      acc = 0;
      for (int i = 0; i < n; i++) acc = acc + longint'(v[i]) * w[i];
      return clamp((acc + (1 << (FB - 1))) >>> FB);
    endfunction

    function void note_query(query_t it);
      interp_t r;
      longint q, xa, xb, xc;
      longint wl[3], wq[3];
      q = it.query;
      xa = nodes[0];
      xb = nodes[1];
      xc = nodes[2];
      r.degenerate = (xa == xb) || (xa == xc) || (xb == xc);
      r.last = it.last;
      r.primal_lin = '0;
      r.adjoint_lin = '0;
      r.primal_quad = '0;
      r.adjoint_quad = '0;
      if (!r.degenerate) begin
        wl[0] = weight_ratio(q - xb, xa - xb);
        wl[1] = weight_ratio(q - xa, xb - xa);
        wl[2] = 0;
        wq[0] = weight_mul(wl[0], weight_ratio(q - xc, xa - xc));
        wq[1] = weight_mul(wl[1], weight_ratio(q - xc, xb - xc));
        wq[2] = weight_mul(weight_ratio(q - xa, xc - xa), weight_ratio(q - xb, xc - xb));
        r.primal_lin = fix_t'(weighted_sum(it.primal, wl, 2));
        r.adjoint_lin = fix_t'(weighted_sum(it.adjoint, wl, 2));
        r.primal_quad = fix_t'(weighted_sum(it.primal, wq, 3));
        r.adjoint_quad = fix_t'(weighted_sum(it.adjoint, wq, 3));
      end
      pending.push_back(r);
    endfunction

    task report(string what, longint got, longint want);
      mismatches++;
      $display("mismatch at result %0d: %s got %0d expected %0d",
               results_seen, what, got, want);
    endtask

    task check_result(interp_t got);
      interp_t want;
      results_seen++;
      if (pending.size() == 0) begin
        report("unexpected item", 1, 0);
        return;
      end
      want = pending.pop_front();
      if (got.degenerate) degenerate_seen++;
      if (got.primal_lin !== want.primal_lin)
        report("primal_linear", got.primal_lin, want.primal_lin);
      if (got.adjoint_lin !== want.adjoint_lin)
        report("adjoint_linear", got.adjoint_lin, want.adjoint_lin);
      if (got.primal_quad !== want.primal_quad)
        report("primal_quadratic", got.primal_quad, want.primal_quad);
      if (got.adjoint_quad !== want.adjoint_quad)
        report("adjoint_quadratic", got.adjoint_quad, want.adjoint_quad);
      if (got.degenerate !== want.degenerate)
        report("nodes_degenerate", got.degenerate, want.degenerate);
      if (got.last !== want.last)
        report("last", got.last, want.last);
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [NUM_IN_VALUES*VW-1:0] s_tdata = '0;
  logic s_tlast = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [NUM_OUT_VALUES*VW-1:0] m_tdata;
  logic m_tuser;
  logic m_tlast;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_NODE_POS_A;
  logic [VW-1:0] cfg_data = '0;

  interp_scoreboard sb = new();
  // While steady is set neither side idles, so back-to-back traffic is covered.
  logic steady = 1'b0;
  int cycles = 0;
  int sent = 0;

  lagrange_interp_1d_lin_quad u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tuser(m_tuser), .m_tlast(m_tlast),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("tb_lagrange_interp_1d_lin_quad: FAIL");
      $finish;
    end
  end

  // Result side: sample an accepted item, then choose the next ready level.
  always @(posedge clk) begin
    interp_t got;
    if (!rst && m_tvalid && m_tready) begin
      got.primal_lin = m_tdata[0 +: VW];
      got.adjoint_lin = m_tdata[VW +: VW];
      got.primal_quad = m_tdata[2*VW +: VW];
      got.adjoint_quad = m_tdata[3*VW +: VW];
      got.degenerate = m_tuser;
      got.last = m_tlast;
      sb.check_result(got);
    end
    m_tready <= steady || ($urandom_range(99) >= 38);
  end

  // Registers are written only while nothing is in flight.
  task write_node(logic [CFG_IDX_W-1:0] idx, fix_t value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.nodes[idx] = value;
  endtask

  task wait_idle();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task set_nodes(fix_t a, fix_t b, fix_t c);
    wait_idle();
    write_node(REG_NODE_POS_A, a);
    write_node(REG_NODE_POS_B, b);
    write_node(REG_NODE_POS_C, c);
  endtask

  // Offer one item and hold it until the block takes it.
  task send_query(query_t it);
    while (!steady && $urandom_range(99) < 38) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {it.adjoint[2], it.adjoint[1], it.adjoint[0],
                it.primal[2], it.primal[1], it.primal[0], it.query};
    s_tlast <= it.last;
    do @(posedge clk); while (!s_tready);
    sb.note_query(it);
    sent++;
  endtask

  // Any 32-bit pattern, biased toward the range limits and small values.
  function fix_t pick_value();
    case ($urandom_range(9))
      0: return fix_t'(VMAX);
      1: return fix_t'(VMIN);
      2, 3: return fix_t'($urandom_range(8 * ONE)) - fix_t'(4 * ONE);
      default: return fix_t'($urandom);
    endcase
  endfunction

  // Queries mostly near the nodes, where the weights stay moderate.
  function fix_t pick_query();
    int k;
    k = $urandom_range(2);
    if ($urandom_range(3) == 0) return pick_value();
    return sb.nodes[k] + fix_t'($urandom_range(4 * ONE)) - fix_t'(2 * ONE);
  endfunction

  function query_t make_query(fix_t q, fix_t v);
    query_t it;
    it.query = q;
    for (int i = 0; i < 3; i++) begin
      it.primal[i] = v;
      it.adjoint[i] = -v;
    end
    it.last = 1'($urandom_range(1));
    return it;
  endfunction

  task run_random(int n);
    query_t it;
    for (int i = 0; i < n; i++) begin
      it.query = pick_query();
      for (int k = 0; k < 3; k++) begin
        it.primal[k] = pick_value();
        it.adjoint[k] = pick_value();
      end
      it.last = ($urandom_range(7) == 0);
      send_query(it);
    end
    s_tvalid <= 1'b0;
  endtask

  initial begin
    query_t it;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part at the reset nodes: queries on each node, between nodes,
    // far outside, and values at the range limits; the last one sets the marker.
    send_query(make_query(fix_t'(0), fix_t'(ONE)));
    send_query(make_query(fix_t'(ONE), fix_t'(VMAX)));
    send_query(make_query(fix_t'(2 * ONE), fix_t'(VMIN)));
    send_query(make_query(fix_t'(ONE / 2), fix_t'(3 * ONE)));
    send_query(make_query(fix_t'(-ONE / 3), fix_t'(-5 * ONE)));
    send_query(make_query(fix_t'(VMAX), fix_t'(VMAX)));
    send_query(make_query(fix_t'(VMIN), fix_t'(VMIN)));
    send_query(make_query(fix_t'(VMIN), fix_t'(0)));
    it = make_query(fix_t'(3 * ONE / 2), fix_t'(0));
    it.primal = '{fix_t'(VMAX), fix_t'(VMIN), fix_t'(VMAX)};
    it.adjoint = '{fix_t'(VMIN), fix_t'(VMAX), fix_t'(-1)};
    it.last = 1'b1;
    send_query(it);
    s_tvalid <= 1'b0;

    // Node coordinates at the range limits.
    set_nodes(fix_t'(VMIN), fix_t'(VMAX), fix_t'(0));
    send_query(make_query(fix_t'(VMAX), fix_t'(VMAX)));
    send_query(make_query(fix_t'(VMIN), fix_t'(VMIN)));
    send_query(make_query(fix_t'(0), fix_t'(ONE)));
    send_query(make_query(fix_t'(12345), fix_t'(-ONE)));
    s_tvalid <= 1'b0;

    // Coinciding nodes: every pair in turn.
    set_nodes(fix_t'(ONE), fix_t'(ONE), fix_t'(3 * ONE));
    send_query(make_query(fix_t'(ONE), fix_t'(VMAX)));
    send_query(make_query(fix_t'(VMIN), fix_t'(VMIN)));
    s_tvalid <= 1'b0;
    set_nodes(fix_t'(-ONE), fix_t'(ONE), fix_t'(-ONE));
    send_query(make_query(fix_t'(0), fix_t'(ONE)));
    s_tvalid <= 1'b0;
    set_nodes(fix_t'(0), fix_t'(VMAX), fix_t'(VMAX));
    send_query(make_query(fix_t'(0), fix_t'(ONE)));
    s_tvalid <= 1'b0;

    // Nodes one LSB apart give huge weights and saturated results.
    set_nodes(fix_t'(0), fix_t'(1), fix_t'(2));
    send_query(make_query(fix_t'(ONE), fix_t'(ONE)));
    send_query(make_query(fix_t'(-ONE), fix_t'(VMAX)));
    s_tvalid <= 1'b0;

    // Random phases over several node settings, one of them with no idling.
    set_nodes(fix_t'(0), fix_t'(ONE), fix_t'(2 * ONE));
    run_random(200);
    set_nodes(fix_t'(3 * ONE), fix_t'(-2 * ONE), fix_t'(ONE / 4));
    steady = 1'b1;
    run_random(200);
    steady = 1'b0;
    set_nodes(fix_t'(VMAX), fix_t'(VMIN), fix_t'(-7));
    run_random(100);
    set_nodes(fix_t'(5), fix_t'(5), fix_t'(-9));
    run_random(50);
    for (int p = 0; p < 4; p++) begin
      set_nodes(pick_value(), pick_value(), pick_value());
      run_random(90);
    end

    wait_idle();
    $display("covered %0d items, %0d results with coinciding nodes, %0d mismatches",
             sent, sb.degenerate_seen, sb.mismatches);
    $display("node settings included range limits, one-LSB spacing and coinciding pairs");
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("tb_lagrange_interp_1d_lin_quad: PASS");
    end else begin
      $display("tb_lagrange_interp_1d_lin_quad: FAIL");
    end
    $finish;
  end

  initial sb.reset_nodes();

endmodule
